// ===== hdl/linear_probing_slot_allocator_assert.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the linear probing slot allocator
// Clocked property checks, compiled out when SYNTHESIS is defined.
// ---------------------------------------------------------------------------
`ifndef LINEAR_PROBING_SLOT_ALLOCATOR_ASSERT_SVH
`define LINEAR_PROBING_SLOT_ALLOCATOR_ASSERT_SVH

`ifndef SYNTHESIS
// check prop at every edge outside reset
`define LPSA_ASSERT(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);
// check prop at every edge, reset included
`define LPSA_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define LPSA_ASSERT(label, clk, rstn, prop, msg)
`define LPSA_ASSERT_ALWAYS(label, clk, prop, msg)
`endif

`endif

// ===== hdl/lpsa_pkg.sv =====
// ---------------------------------------------------------------------------
// lpsa_pkg
// Shared types and constants of the linear probing slot allocator.
// ---------------------------------------------------------------------------
package lpsa_pkg;

    // default slot capacity of the map memory
    localparam int MAX_SLOTS_DEF = 1024;

    // fixed field widths
    localparam int MEMBER_W   = 31;
    localparam int CFG_W      = 11;
    localparam int SLOT_IDX_W = 10;

    // batch tag width of a map entry; tag zero marks a free entry
    localparam int EPOCH_W = 8;

    // table size after reset
    localparam logic [CFG_W-1:0] TABLE_SIZE_RST = 11'd1024;

    // request payload
    typedef struct packed {
        logic [MEMBER_W-1:0] member_id;
        logic                last_request;
    } req_t;

    // result payload
    typedef struct packed {
        logic [SLOT_IDX_W-1:0] slot_index;
        logic                  table_full;
    } resp_t;

    // control sequencer states
    typedef enum logic [4:0] {
        S_CLEAR  = 5'b00001,
        S_IDLE   = 5'b00010,
        S_DIV    = 5'b00100,
        S_PROBE  = 5'b01000,
        S_FINISH = 5'b10000
    } state_t;

endpackage

// ===== hdl/lpsa_mod_unit.sv =====
// ---------------------------------------------------------------------------
// lpsa_mod_unit
// Restoring remainder unit: one dividend bit per cycle.
// ---------------------------------------------------------------------------
module lpsa_mod_unit
    import lpsa_pkg::*;
#(
    parameter int DVD_W = MEMBER_W,
    parameter int DSR_W = 11
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start,
    input  logic [DVD_W-1:0] dividend,
    input  logic [DSR_W-1:0] divisor,
    output logic             done,
    output logic [DSR_W-1:0] remainder
);

    localparam int STEP_W = $clog2(DVD_W + 1);

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic [DVD_W-1:0]  dvd_reg, dvd_next;
    logic [DSR_W-1:0]  rem_reg, rem_next;
    logic [DSR_W:0]    trial;

    // shift in the next dividend bit and subtract when it fits
    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        step_next = step_reg;
        dvd_next  = dvd_reg;
        rem_next  = rem_reg;
        trial     = {rem_reg, dvd_reg[DVD_W-1]};
        if (start) begin
            busy_next = 1'b1;
            step_next = '0;
            dvd_next  = dividend;
            rem_next  = '0;
        end else if (busy_reg) begin
            if (trial >= {1'b0, divisor}) begin
                rem_next = DSR_W'(trial - {1'b0, divisor});
            end else begin
                rem_next = trial[DSR_W-1:0];
            end
            dvd_next  = {dvd_reg[DVD_W-2:0], 1'b0};
            step_next = step_reg + STEP_W'(1);
            if (step_reg == STEP_W'(DVD_W - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    // datapath
    always_ff @(posedge aclk) begin
        dvd_reg <= dvd_next;
        rem_reg <= rem_next;
    end

    assign done      = done_reg;
    assign remainder = rem_reg;

endmodule

// ===== hdl/lpsa_slot_map.sv =====
// ---------------------------------------------------------------------------
// lpsa_slot_map
// Slot map memory: one batch tag per slot, one write and one read port.
// ---------------------------------------------------------------------------
module lpsa_slot_map
    import lpsa_pkg::*;
#(
    parameter int DEPTH  = MAX_SLOTS_DEF,
    parameter int ADDR_W = 10,
    parameter int DATA_W = EPOCH_W
) (
    input  logic              aclk,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [DATA_W-1:0] rd_data,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [DATA_W-1:0] wr_data
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rd_data_reg;

    // write port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // registered read port
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== hdl/linear_probing_slot_allocator.sv =====
// ---------------------------------------------------------------------------
// linear_probing_slot_allocator
// Hashes each member number into a slot table and claims the first free
// slot by linear probing.
// ---------------------------------------------------------------------------
// Usage:
//   Requests (member_id, last_request) arrive on s_valid/s_ready/s_data and
//   one result (slot_index, table_full) leaves per request on
//   m_valid/m_ready/m_data. table_size is written on cfg_valid/cfg_ready/
//   cfg_data while the block is idle, a rule on the user that the block
//   itself does not enforce; cfg_ready is always high. After the request
//   transfer the bit-serial remainder unit finds the home slot, a setup
//   step loads the probe pointer, one probe read per slot visited goes
//   through the registered map read, and a finish step loads the result.
//   One request is in flight at a time; the next is taken once the result
//   loads. A full table is probed over every slot and claims none.
//   The map stores a batch tag per slot; a request flagged last_request
//   starts a new batch, which frees every slot at once. After reset, and
//   once every 255 batches when the tag wraps, a clearing pass writes the
//   free tag to all MAX_SLOTS entries; no request is accepted during it.
//   The result sits in an output register, so the next request is accepted
//   while it waits; a stalled receiver holds the finish step of the
//   following request until the register empties.
// ---------------------------------------------------------------------------
`include "linear_probing_slot_allocator_assert.svh"

module linear_probing_slot_allocator
    import lpsa_pkg::*;
#(
    parameter int MAX_SLOTS = MAX_SLOTS_DEF
) (
    input  logic             aclk,
    input  logic             aresetn,
    // configuration write
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [CFG_W-1:0] cfg_data,
    // request channel
    input  logic             s_valid,
    output logic             s_ready,
    input  req_t             s_data,
    // result channel
    output logic             m_valid,
    input  logic             m_ready,
    output resp_t            m_data
);

    localparam int SLOT_W = $clog2(MAX_SLOTS);
    localparam int CNT_W  = $clog2(MAX_SLOTS + 1);

    state_t              state_reg, state_next;
    logic [CFG_W-1:0]    table_size_reg;
    logic [CNT_W-1:0]    eff_size;
    logic [CNT_W-1:0]    size_reg, size_next;
    logic [EPOCH_W-1:0]  epoch_reg, epoch_next;
    logic [SLOT_W-1:0]   clr_ptr_reg, clr_ptr_next;
    logic [SLOT_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]    iss_cnt_reg, iss_cnt_next;
    logic                chk_vld_reg, chk_vld_next;
    logic [SLOT_W-1:0]   chk_addr_reg, chk_addr_next;
    logic                found_reg, found_next;
    logic [SLOT_W-1:0]   slot_reg, slot_next;
    logic                last_reg;
    logic                m_valid_reg, m_valid_next;
    resp_t               m_data_reg, m_data_next;

    logic                accept;
    logic                div_done;
    logic [CNT_W-1:0]    div_rem;
    logic                issue;
    logic                found_now;
    logic                full_now;
    logic                load_out;
    logic [CNT_W-1:0]    ptr_inc;
    logic [31:0]         slot_ext;
    logic [EPOCH_W-1:0]  rd_tag;
    logic                map_wr_en;
    logic [SLOT_W-1:0]   map_wr_addr;
    logic [EPOCH_W-1:0]  map_wr_data;

    assign cfg_ready = 1'b1;
    assign s_ready   = (state_reg == S_IDLE);
    assign accept    = s_valid && s_ready;

    // clamp the configured size into 1..MAX_SLOTS
    always_comb begin
        if (table_size_reg == '0) begin
            eff_size = CNT_W'(1);
        end else if (32'(table_size_reg) > 32'(MAX_SLOTS)) begin
            eff_size = CNT_W'(MAX_SLOTS);
        end else begin
            eff_size = CNT_W'(table_size_reg);
        end
    end

    // home slot = member_id mod size
    lpsa_mod_unit #(
        .DVD_W(MEMBER_W),
        .DSR_W(CNT_W)
    ) u_mod (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (accept),
        .dividend  (s_data.member_id),
        .divisor   (eff_size),
        .done      (div_done),
        .remainder (div_rem)
    );

    // used map: entry is taken when its tag equals the current batch tag
    lpsa_slot_map #(
        .DEPTH (MAX_SLOTS),
        .ADDR_W(SLOT_W),
        .DATA_W(EPOCH_W)
    ) u_map (
        .aclk    (aclk),
        .rd_en   (issue),
        .rd_addr (rd_ptr_reg),
        .rd_data (rd_tag),
        .wr_en   (map_wr_en),
        .wr_addr (map_wr_addr),
        .wr_data (map_wr_data)
    );

    // probe decode on the returned map word
    assign found_now = chk_vld_reg && (rd_tag != epoch_reg);
    assign full_now  = chk_vld_reg && !found_now && (iss_cnt_reg == size_reg);
    assign issue     = (state_reg == S_PROBE) && (iss_cnt_reg != size_reg) && !found_now;
    assign ptr_inc   = CNT_W'(rd_ptr_reg) + CNT_W'(1);
    assign load_out  = (state_reg == S_FINISH) && (!m_valid_reg || m_ready);
    assign slot_ext  = 32'(slot_reg);

    // map writes: clearing pass, or claim of the found slot
    always_comb begin
        map_wr_en   = 1'b0;
        map_wr_addr = slot_reg;
        map_wr_data = epoch_reg;
        if (state_reg == S_CLEAR) begin
            map_wr_en   = 1'b1;
            map_wr_addr = clr_ptr_reg;
            map_wr_data = '0;
        end else if (load_out && found_reg) begin
            map_wr_en = 1'b1;
        end
    end

    // sequencer
    always_comb begin
        state_next    = state_reg;
        size_next     = size_reg;
        epoch_next    = epoch_reg;
        clr_ptr_next  = clr_ptr_reg;
        rd_ptr_next   = rd_ptr_reg;
        iss_cnt_next  = iss_cnt_reg;
        chk_vld_next  = 1'b0;
        chk_addr_next = chk_addr_reg;
        found_next    = found_reg;
        slot_next     = slot_reg;
        m_valid_next  = m_valid_reg && !m_ready;
        m_data_next   = m_data_reg;
        unique case (state_reg)
            S_CLEAR: begin
                clr_ptr_next = clr_ptr_reg + SLOT_W'(1);
                if (clr_ptr_reg == SLOT_W'(MAX_SLOTS - 1)) begin
                    clr_ptr_next = '0;
                    epoch_next   = EPOCH_W'(1);
                    state_next   = S_IDLE;
                end
            end
            S_IDLE: begin
                if (accept) begin
                    size_next  = eff_size;
                    state_next = S_DIV;
                end
            end
            S_DIV: begin
                if (div_done) begin
                    rd_ptr_next  = div_rem[SLOT_W-1:0];
                    iss_cnt_next = '0;
                    state_next   = S_PROBE;
                end
            end
            S_PROBE: begin
                // advance the read pointer, wrapping at the table size
                if (issue) begin
                    chk_vld_next  = 1'b1;
                    chk_addr_next = rd_ptr_reg;
                    iss_cnt_next  = iss_cnt_reg + CNT_W'(1);
                    if (ptr_inc >= size_reg) begin
                        rd_ptr_next = '0;
                    end else begin
                        rd_ptr_next = ptr_inc[SLOT_W-1:0];
                    end
                end
                if (found_now) begin
                    found_next = 1'b1;
                    slot_next  = chk_addr_reg;
                    state_next = S_FINISH;
                end else if (full_now) begin
                    found_next = 1'b0;
                    slot_next  = '0;
                    state_next = S_FINISH;
                end
            end
            S_FINISH: begin
                if (load_out) begin
                    m_valid_next           = 1'b1;
                    m_data_next.slot_index = slot_ext[SLOT_IDX_W-1:0];
                    m_data_next.table_full = !found_reg;
                    state_next             = S_IDLE;
                    // start a new batch; rewrite the map when the tag wraps
                    if (last_reg) begin
                        if (epoch_reg == '1) begin
                            clr_ptr_next = '0;
                            state_next   = S_CLEAR;
                        end else begin
                            epoch_next = epoch_reg + EPOCH_W'(1);
                        end
                    end
                end
            end
            default: begin
                state_next = S_CLEAR;
            end
        endcase
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_CLEAR;
            table_size_reg <= TABLE_SIZE_RST;
            epoch_reg      <= EPOCH_W'(1);
            clr_ptr_reg    <= '0;
            chk_vld_reg    <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg   <= state_next;
            epoch_reg   <= epoch_next;
            clr_ptr_reg <= clr_ptr_next;
            chk_vld_reg <= chk_vld_next;
            m_valid_reg <= m_valid_next;
            if (cfg_valid && cfg_ready) begin
                table_size_reg <= cfg_data;
            end
        end
    end

    // request and probe datapath
    always_ff @(posedge aclk) begin
        size_reg     <= size_next;
        rd_ptr_reg   <= rd_ptr_next;
        iss_cnt_reg  <= iss_cnt_next;
        chk_addr_reg <= chk_addr_next;
        found_reg    <= found_next;
        slot_reg     <= slot_next;
        m_data_reg   <= m_data_next;
        if (accept) begin
            last_reg <= s_data.last_request;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // a full-table result never carries a slot number
    `LPSA_ASSERT(a_full_slot_zero, aclk, aresetn, (m_valid && m_data.table_full) |-> (m_data.slot_index == '0), "full result with nonzero slot")
    // a claimed slot lies inside the table
    `LPSA_ASSERT(a_claim_in_table, aclk, aresetn, (load_out && found_reg) |-> (CNT_W'(slot_reg) < size_reg), "claimed slot outside table")
    // the free tag is never the live batch tag
    `LPSA_ASSERT(a_epoch_nonzero, aclk, aresetn, (state_reg != S_CLEAR) |-> (epoch_reg != '0), "batch tag zero outside clearing")
    // no probe read runs past the table size
    `LPSA_ASSERT(a_probe_bound, aclk, aresetn, (state_reg == S_PROBE) |-> (iss_cnt_reg <= size_reg), "probe count past table size")
    // the divide starts only on a request transfer
    `LPSA_ASSERT(a_div_after_accept, aclk, aresetn, $rose(state_reg == S_DIV) |-> $past(accept), "divide started without a request")

endmodule

// ===== tb/lpsa_slot_monitor.sv =====
// ----------------------------------------------------------------------------
// lpsa_slot_monitor
// Watches the configuration, request and result channels of the slot
// allocator. It keeps its own slot map, predicts each result and compares it
// field by field with what the block returns. Mismatches are counted and
// handed to the testbench top.
// ----------------------------------------------------------------------------
module lpsa_slot_monitor
    import lpsa_pkg::*;
#(
    parameter int MAX_SLOTS = MAX_SLOTS_DEF
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             cfg_valid,
    input  logic             cfg_ready,
    input  logic [CFG_W-1:0] cfg_data,
    input  logic             s_valid,
    input  logic             s_ready,
    input  req_t             s_data,
    input  logic             m_valid,
    input  logic             m_ready,
    input  resp_t            m_data,
    output int               errors,
    output int               pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int COUNT_SAT = 2047;

    // shadow of the table size register and of the slot map
    logic [CFG_W-1:0] size_reg;
    bit               slot_taken [MAX_SLOTS];
    int               taken_count;
    resp_t            expected_slots [$];

    // print one line per mismatch and count it
    task automatic flag_mismatch(input string what, input int got, input int want);
        errors++;
        $display("[%0t] %s: got %0d, expected %0d", $time, what, got, want);
    endtask

    // free every slot
    task automatic clear_slots();
        foreach (slot_taken[i]) begin
            slot_taken[i] = 1'b0;
        end
        taken_count = 0;
    endtask

    // zero acts as one, anything above the map capacity saturates
    function automatic int unsigned active_size();
        int unsigned size;
        size = size_reg;
        if (size == 0) begin
            size = 1;
        end
        if (size > MAX_SLOTS) begin
            size = MAX_SLOTS;
        end
        return size;
    endfunction

    // hash to the home slot, walk forward to the first free slot, claim it
    task automatic claim_slot(input req_t req);
        int unsigned size;
        int unsigned slot;
        bit          found;
        resp_t       res;
        size  = active_size();
        slot  = req.member_id % size;
        found = 1'b0;
        for (int tries = 0; tries < size; tries++) begin
            if (!slot_taken[slot]) begin
                found = 1'b1;
                break;
            end
            slot = slot + 1;
            if (slot >= size) begin
                slot = 0;
            end
        end
        res = '0;
        if (found) begin
            slot_taken[slot] = 1'b1;
            if (taken_count < COUNT_SAT) begin
                taken_count++;
            end
            res.slot_index = SLOT_IDX_W'(slot);
        end else begin
            res.table_full = 1'b1;
        end
        // a last request clears the map even when the table was full
        if (req.last_request) begin
            clear_slots();
        end
        expected_slots = {expected_slots, res};
    endtask

    // sample every channel at the rising edge
    always @(posedge aclk) begin
        resp_t want;
        if (!aresetn) begin
            size_reg = TABLE_SIZE_RST;
            clear_slots();
            expected_slots.delete();
        end else begin
            // compare a result transfer with the oldest prediction
            if (m_valid && m_ready) begin
                if (expected_slots.size() == 0) begin
                    flag_mismatch("result with no request pending", m_data.slot_index, -1);
                end else begin
                    want = expected_slots.pop_front();
                    if (m_data.slot_index !== want.slot_index) begin
                        flag_mismatch("slot_index", m_data.slot_index, want.slot_index);
                    end
                    if (m_data.table_full !== want.table_full) begin
                        flag_mismatch("table_full", m_data.table_full, want.table_full);
                    end
                end
            end
            // a request at the same edge as a size write still sees the old size
            if (s_valid && s_ready) begin
                claim_slot(s_data);
            end
            if (cfg_valid && cfg_ready) begin
                size_reg = cfg_data;
            end
        end
        pending = expected_slots.size();
    end

endmodule

// ===== tb/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Stimulus and verdict for the linear probing slot allocator. A directed
// opening covers field extremes, wrap, full tables, size zero and saturation,
// and table shrink; random phases at many table sizes follow, with batches
// that fill the table, random idling on both sides, a long result stall and
// a drain pause. Checking is done by lpsa_slot_monitor.
// ----------------------------------------------------------------------------
module tb
    import lpsa_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int  NUM_ITEMS   = 1800;
    localparam int  HOLD_AT     = 700;
    localparam int  DRAIN_AT    = 1100;
    localparam int  CALM_AT     = 1600;
    localparam int  HOLD_CYCLES = 400;
    localparam int  TAIL_CYCLES = 1100;
    localparam time RUN_LIMIT   = 160_000_000;

    logic             aclk      = 1'b0;
    logic             aresetn   = 1'b0;
    logic             cfg_valid = 1'b0;
    logic             cfg_ready;
    logic [CFG_W-1:0] cfg_data  = '0;
    logic             s_valid   = 1'b0;
    logic             s_ready;
    req_t             s_data    = '0;
    logic             m_valid;
    logic             m_ready   = 1'b0;
    resp_t            m_data;

    int          errors;
    int          pending;
    int          sent         = 0;
    bit          calm         = 1'b0;
    bit          hold_req     = 1'b0;
    bit          sender_quiet = 1'b0;
    int unsigned cur_size     = MAX_SLOTS_DEF;

    linear_probing_slot_allocator #(
        .MAX_SLOTS(MAX_SLOTS_DEF)
    ) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data (cfg_data),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_data   (s_data),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_data   (m_data)
    );

    lpsa_slot_monitor #(
        .MAX_SLOTS(MAX_SLOTS_DEF)
    ) monitor (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data (cfg_data),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_data   (s_data),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_data   (m_data),
        .errors   (errors),
        .pending  (pending)
    );

    initial begin
        forever #10 aclk = ~aclk;
    end

    // abort a hung run
    initial begin
        #(RUN_LIMIT);
        $display("status: fail");
        $finish;
    end

    // result side: random stall bursts, quiet stretches, one long hold-off
    initial begin
        int hold_left;
        int idle_left;
        int mode_left;
        bit stall_mode;
        bit hold_seen;
        hold_left  = 0;
        idle_left  = 0;
        mode_left  = 0;
        stall_mode = 1'b1;
        hold_seen  = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_req && !hold_seen) begin
                hold_seen = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (mode_left == 0) begin
                mode_left  = $urandom_range(50, 300);
                stall_mode = ($urandom_range(0, 2) != 0);
            end else begin
                mode_left--;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else if (idle_left > 0) begin
                idle_left--;
                m_ready <= 1'b0;
            end else if (!calm && stall_mode && $urandom_range(0, 5) == 0) begin
                idle_left = $urandom_range(1, 3) - 1;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // offer one request, hold it until the transfer, return at a falling edge
    task automatic send_request(input logic [MEMBER_W-1:0] member, input logic last);
        int gap;
        if (!calm && !sender_quiet && $urandom_range(0, 4) == 0) begin
            gap = $urandom_range(1, 3);
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= '{member_id: member, last_request: last};
        do @(posedge aclk); while (!s_ready);
        sent++;
        @(negedge aclk);
    endtask

    // stop offering and wait for every predicted result
    task automatic drain();
        s_valid <= 1'b0;
        while (pending != 0) @(negedge aclk);
    endtask

    // write the table size once the block is idle
    task automatic write_size(input logic [CFG_W-1:0] size);
        drain();
        cfg_valid <= 1'b1;
        cfg_data  <= size;
        do @(posedge aclk); while (!cfg_ready);
        @(negedge aclk);
        cfg_valid <= 1'b0;
        cur_size = (size == 0) ? 1 : (size > MAX_SLOTS_DEF) ? MAX_SLOTS_DEF : size;
    endtask

    // member numbers: extremes, full range, home slot near the end, small spread
    function automatic logic [MEMBER_W-1:0] pick_member(input int unsigned size);
        logic [MEMBER_W-1:0] member;
        case ($urandom_range(0, 9))
            0:       member = '1;
            1:       member = '0;
            2:       member = MEMBER_W'($urandom);
            3:       member = MEMBER_W'(size * $urandom_range(0, 1000) + size - 1);
            default: member = MEMBER_W'($urandom_range(0, 4 * size));
        endcase
        return member;
    endfunction

    initial begin
        int unsigned size;
        int          phase_items;
        int          batch_left;
        logic        last;

        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // reset size: extremes of member_id, collision and wrap, batch clear
        send_request(31'd0, 1'b0);
        send_request('1, 1'b0);
        send_request(31'd1024, 1'b0);
        send_request(31'd2047, 1'b0);
        send_request(31'd5, 1'b1);
        send_request(31'd0, 1'b0);

        // size zero acts as one slot: full table, full with batch clear
        write_size('0);
        send_request(31'd12345, 1'b0);
        send_request(31'd7, 1'b0);
        send_request(31'd9, 1'b1);
        send_request(31'd3, 1'b0);

        // oversized table saturates at the map capacity
        write_size('1);
        send_request(31'd1500, 1'b0);
        send_request('1, 1'b1);

        // fill a three slot table, then hit it full
        write_size(11'd3);
        send_request(31'd0, 1'b0);
        send_request(31'd4, 1'b0);
        send_request(31'd8, 1'b0);
        send_request(31'd1, 1'b0);
        send_request(31'd2, 1'b1);

        // shrink with marks above the new size, then grow back
        write_size(11'd8);
        send_request(31'd5, 1'b0);
        send_request(31'd6, 1'b0);
        send_request(31'd7, 1'b0);
        write_size(11'd4);
        send_request(31'd5, 1'b0);
        send_request(31'd3, 1'b0);
        write_size(11'd8);
        send_request(31'd13, 1'b0);
        send_request(31'd21, 1'b1);

        // random phases: mostly small tables, batches sized to fill them
        while (sent < NUM_ITEMS) begin
            case ($urandom_range(0, 19))
                0:       size = $urandom_range(1000, 2047);
                1:       size = 0;
                2:       size = 1;
                default: size = $urandom_range(2, 64);
            endcase
            write_size(CFG_W'(size));
            sender_quiet = ($urandom_range(0, 3) == 0);
            phase_items  = (cur_size > 128) ? $urandom_range(5, 12) : $urandom_range(30, 120);
            batch_left   = 0;
            for (int i = 0; i < phase_items && sent < NUM_ITEMS; i++) begin
                if (batch_left == 0) begin
                    batch_left = (cur_size > 128) ? $urandom_range(1, 12)
                                                  : $urandom_range(1, cur_size + 3);
                end
                // end the batch on its last item, plus a stray clear now and then
                last = (batch_left == 1) || ($urandom_range(0, 49) == 0);
                batch_left--;
                send_request(pick_member(cur_size), last);
                if (sent == HOLD_AT) begin
                    hold_req = 1'b1;
                end
                if (sent == DRAIN_AT) begin
                    drain();
                end
                if (sent >= CALM_AT) begin
                    calm = 1'b1;
                end
            end
        end

        // wait out the last results and any stray activity
        drain();
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (errors == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+hdl
hdl/lpsa_pkg.sv
hdl/lpsa_mod_unit.sv
hdl/lpsa_slot_map.sv
hdl/linear_probing_slot_allocator.sv
tb/lpsa_slot_monitor.sv
tb/tb.sv
